// File: sv/pfa_pkg.sv
package pfa_pkg;

  localparam int unsigned PAGE_SLOTS = 256;
  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned CONT_MARK  = 511;

  localparam int unsigned SLOT_AW    = $clog2(PAGE_SLOTS);
  localparam int unsigned CNT_W      = SLOT_AW + 1;
  localparam int unsigned SLOT_W     = $clog2(CONT_MARK + 1);
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_BYTES);

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD     = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_OUTSIDE = 3'd3,
    ST_NOTHEAD = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CFG_BASE_ADDRESS = 2'd0,
    CFG_REGION_PAGES = 2'd1,
    CFG_REGION_BYTES = 2'd2
  } cfg_idx_e;

  // Command from the sequencer to the page table.
  typedef struct packed {
    logic               wr_en;
    logic               clr_en;
    logic               rd_en;
    logic [SLOT_AW-1:0] addr;
    logic [SLOT_W-1:0]  wdata;
  } slot_cmd_t;

  // Registered read result of the page table.
  typedef struct packed {
    logic              used;
    logic [SLOT_W-1:0] data;
  } slot_rsp_t;

endpackage

// File: sv/page_first_fit_allocator.sv
// Allocate: the sequencer checks the request, scans for the first free run of pages, marks it
// and returns its address; a miss ends after the scan and a bad request before it.
// Free: clears the run from its head slot; stops outside the region or on a non-head page.
// The sequencer scans, marks or clears one page-table slot per cycle, one request at a time;
// busy_o is low again in the cycle that done_o strobes, and the receiver cannot stall.
// Reset marks every page free, clears the configuration registers and idles the sequencer.
module page_first_fit_allocator
  import pfa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [31:0] size_bytes_i,
  input  logic [31:0] free_address_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] alloc_address_o
);

  logic [31:0]        base_address_q;
  logic [8:0]         region_pages_q;
  logic [31:0]        region_bytes_q;
  slot_cmd_t          cmd;
  slot_rsp_t          rsp;
  logic [SLOT_AW-1:0] probe_addr;
  logic               probe_used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= '0;
      region_pages_q <= '0;
      region_bytes_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BASE_ADDRESS: base_address_q <= cfg_wdata_i;
        CFG_REGION_PAGES: region_pages_q <= cfg_wdata_i[8:0];
        CFG_REGION_BYTES: region_bytes_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  pfa_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .req_type_i      (req_type_i),
    .size_bytes_i    (size_bytes_i),
    .free_address_i  (free_address_i),
    .base_address_i  (base_address_q),
    .region_pages_i  (region_pages_q),
    .region_bytes_i  (region_bytes_q),
    .busy_o          (busy_o),
    .cmd_o           (cmd),
    .probe_addr_o    (probe_addr),
    .probe_used_i    (probe_used),
    .rsp_i           (rsp),
    .done_o          (done_o),
    .status_o        (status_o),
    .alloc_address_o (alloc_address_o)
  );

  pfa_slot_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .probe_addr_i (probe_addr),
    .probe_used_o (probe_used),
    .rsp_o        (rsp)
  );

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("accepted request did not make the block busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobed while the sequencer is still busy");

  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("request finished without a result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != ST_OK |-> alloc_address_o == 32'd0)
    else $error("failed request reported a nonzero address");

endmodule

// File: sv/pfa_slot_store.sv
module pfa_slot_store
  import pfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  slot_cmd_t          cmd_i,
  input  logic [SLOT_AW-1:0] probe_addr_i,
  output logic               probe_used_o,
  output slot_rsp_t          rsp_o
);

  // A slot whose used bit is clear reads as free, whatever the memory holds.
  logic [PAGE_SLOTS-1:0] used_q;
  logic [SLOT_W-1:0]     mem_q [PAGE_SLOTS];
  slot_rsp_t             rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.wr_en) begin
      used_q[cmd_i.addr] <= 1'b1;
    end else if (cmd_i.clr_en) begin
      used_q[cmd_i.addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.addr] <= cmd_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rsp_q.used <= used_q[cmd_i.addr];
      rsp_q.data <= mem_q[cmd_i.addr];
    end
  end

  assign probe_used_o = used_q[probe_addr_i];
  assign rsp_o        = rsp_q;

endmodule

// File: sv/pfa_seq.sv
module pfa_seq
  import pfa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               req_type_i,
  input  logic [31:0]        size_bytes_i,
  input  logic [31:0]        free_address_i,
  input  logic [31:0]        base_address_i,
  input  logic [8:0]         region_pages_i,
  input  logic [31:0]        region_bytes_i,
  output logic               busy_o,
  output slot_cmd_t          cmd_o,
  output logic [SLOT_AW-1:0] probe_addr_o,
  input  logic               probe_used_i,
  input  slot_rsp_t          rsp_i,
  output logic               done_o,
  output logic [2:0]         status_o,
  output logic [31:0]        alloc_address_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ACHK  = 9'b000000010,
    S_SCAN  = 9'b000000100,
    S_MARK  = 9'b000001000,
    S_ADDR  = 9'b000010000,
    S_FCHK  = 9'b000100000,
    S_FIDX  = 9'b001000000,
    S_FREAD = 9'b010000000,
    S_CLR   = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [31:0]        size_q, addr_q;
  logic [SLOT_W-1:0]  pages_q, pages_d;
  logic [SLOT_W-1:0]  run_q, run_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [CNT_W-1:0]   limit_q, limit_d;
  logic [SLOT_AW-1:0] start_q, start_d;
  logic [SLOT_AW-1:0] end_q, end_d;
  logic [SLOT_AW-1:0] ptr_q, ptr_d;
  logic [32:0]        off_q, off_d;
  logic               over_q, over_d;
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [31:0]        res_addr_q, res_addr_d;

  logic [32:0]        pages_full;
  logic [32:0]        end_sum;
  logic [SLOT_W-1:0]  run_inc;

  assign pages_full = ({1'b0, size_q} + 33'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
  assign end_sum    = {1'b0, base_address_i} + {1'b0, region_bytes_i};
  assign run_inc    = run_q + SLOT_W'(1);

  always_comb begin
    state_d    = state_q;
    pages_d    = pages_q;
    run_d      = run_q;
    k_d        = k_q;
    limit_d    = limit_q;
    start_d    = start_q;
    end_d      = end_q;
    ptr_d      = ptr_q;
    off_d      = off_q;
    over_d     = over_q;
    done_d     = 1'b0;
    status_d   = status_q;
    res_addr_d = res_addr_q;
    cmd_o      = '0;
    cmd_o.addr = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = req_type_i ? S_FCHK : S_ACHK;
        end
      end
      S_ACHK: begin
        if (pages_full == 33'd0 || pages_full >= 33'(CONT_MARK) || base_address_i == 32'd0) begin
          state_d    = S_IDLE;
          done_d     = 1'b1;
          status_d   = ST_BAD;
          res_addr_d = '0;
        end else begin
          pages_d = SLOT_W'(pages_full);
          run_d   = '0;
          k_d     = '0;
          limit_d = (32'(region_pages_i) > PAGE_SLOTS) ? CNT_W'(PAGE_SLOTS)
                                                       : CNT_W'(region_pages_i);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_q >= limit_q) begin
          state_d    = S_IDLE;
          done_d     = 1'b1;
          status_d   = ST_NOMEM;
          res_addr_d = '0;
        end else begin
          k_d = k_q + CNT_W'(1);
          if (probe_used_i) begin
            run_d = '0;
          end else if (run_inc == pages_q) begin
            start_d = SLOT_AW'(k_q + CNT_W'(1) - CNT_W'(pages_q));
            ptr_d   = SLOT_AW'(k_q + CNT_W'(1) - CNT_W'(pages_q));
            end_d   = k_q[SLOT_AW-1:0];
            state_d = S_MARK;
          end else begin
            run_d = run_inc;
          end
        end
      end
      S_MARK: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wdata = (ptr_q == start_q) ? pages_q : SLOT_W'(CONT_MARK);
        ptr_d       = ptr_q + SLOT_AW'(1);
        if (ptr_q == end_q) begin
          state_d = S_ADDR;
        end
      end
      S_ADDR: begin
        state_d    = S_IDLE;
        done_d     = 1'b1;
        status_d   = ST_OK;
        res_addr_d = base_address_i + (32'(start_q) << PAGE_SHIFT);
      end
      S_FCHK: begin
        off_d   = {1'b0, addr_q} - {1'b0, base_address_i};
        over_d  = {1'b0, addr_q} >= end_sum;
        state_d = S_FIDX;
      end
      S_FIDX: begin
        // Bit 32 of the difference is the borrow: the address lies below the base.
        if (off_q[32] || over_q || 32'(off_q[31:PAGE_SHIFT]) >= PAGE_SLOTS) begin
          state_d    = S_IDLE;
          done_d     = 1'b1;
          status_d   = ST_OUTSIDE;
          res_addr_d = '0;
        end else begin
          cmd_o.rd_en = 1'b1;
          cmd_o.addr  = SLOT_AW'(off_q[31:PAGE_SHIFT]);
          ptr_d       = SLOT_AW'(off_q[31:PAGE_SHIFT]);
          state_d     = S_FREAD;
        end
      end
      S_FREAD: begin
        if (!rsp_i.used || rsp_i.data == SLOT_W'(CONT_MARK)) begin
          state_d    = S_IDLE;
          done_d     = 1'b1;
          status_d   = ST_NOTHEAD;
          res_addr_d = '0;
        end else begin
          pages_d = rsp_i.data;
          state_d = S_CLR;
        end
      end
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        ptr_d        = ptr_q + SLOT_AW'(1);
        pages_d      = pages_q - SLOT_W'(1);
        // The run is cut short at the last slot of the table.
        if (pages_q == SLOT_W'(1) || ptr_q == SLOT_AW'(PAGE_SLOTS - 1)) begin
          state_d    = S_IDLE;
          done_d     = 1'b1;
          status_d   = ST_OK;
          res_addr_d = '0;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      size_q <= size_bytes_i;
      addr_q <= free_address_i;
    end
    pages_q    <= pages_d;
    run_q      <= run_d;
    k_q        <= k_d;
    limit_q    <= limit_d;
    start_q    <= start_d;
    end_q      <= end_d;
    ptr_q      <= ptr_d;
    off_q      <= off_d;
    over_q     <= over_d;
    status_q   <= status_d;
    res_addr_q <= res_addr_d;
  end

  assign busy_o          = (state_q != S_IDLE);
  assign probe_addr_o    = k_q[SLOT_AW-1:0];
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign alloc_address_o = res_addr_q;

endmodule
